### rtl/core/stx_etx_packet_deframer_defines.svh
// Assertion macros for the deframer modules; only sedf_back includes them.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef STX_ETX_PACKET_DEFRAMER_DEFINES_SVH
`define STX_ETX_PACKET_DEFRAMER_DEFINES_SVH

// Antecedent in a cycle implies the consequent in the same cycle.
`define SEDF_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Antecedent in a cycle implies the consequent in the next cycle.
`define SEDF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### rtl/core/sedf_pkg.sv
package sedf_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int ADDR_W      = $clog2(MAX_FRAME);
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int TRAILER_LEN = 4;
  localparam int TCNT_W      = 3;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  localparam logic [7:0] START_RESET  = 8'd2;
  localparam logic [7:0] END_RESET    = 8'd3;
  localparam logic [7:0] ESCAPE_RESET = 8'd16;

  // Result kinds.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Work handed from the front to the back.
  typedef struct packed {
    logic             is_err;
    logic [7:0]       data;
    logic [CNT_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic cmd_full;
    logic frame_done;
  } back_status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } out_item_t;

endpackage

### rtl/core/sedf_ram.sv
module sedf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sedf_front.sv
module sedf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [7:0]                  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  rx_byte,
  input  sedf_pkg::back_status_t      status,
  output logic                        cmd_push,
  output sedf_pkg::cmd_t              cmd,
  output logic                        mem_we,
  output logic [sedf_pkg::ADDR_W-1:0] mem_waddr,
  output logic [7:0]                  mem_wdata
);

  import sedf_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_BODY, PH_TRAIL} phase_t;

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [TCNT_W-1:0] tcount, tcount_next, tcount_inc;
  logic              hold, hold_next;
  logic [7:0]        start_byte, end_byte, escape_byte;
  logic [7:0]        byte1, byte2;
  logic              accept;

  assign full   = status.cmd_full || hold;
  assign accept = push && !full;
  assign tcount_inc = tcount + 1'b1;
  assign mem_wdata  = rx_byte;

  always_comb begin
    phase_next  = phase;
    count_next  = count;
    tcount_next = tcount;
    hold_next   = hold && !status.frame_done;
    mem_we      = 1'b0;
    mem_waddr   = count[ADDR_W-1:0];
    cmd_push    = 1'b0;
    cmd.is_err  = 1'b0;
    cmd.data    = (byte1 == escape_byte) ? byte2 : byte1;
    cmd.len     = count + 1'b1;
    if (accept) begin
      unique case (phase)
        PH_BODY, PH_TRAIL: begin
          if (count == CNT_W'(MAX_FRAME)) begin
            // The store is full: the frame is dropped and reported.
            cmd_push    = 1'b1;
            cmd.is_err  = 1'b1;
            phase_next  = PH_IDLE;
            count_next  = '0;
            tcount_next = '0;
          end else if (rx_byte == start_byte) begin
            mem_we      = 1'b1;
            mem_waddr   = '0;
            count_next  = CNT_W'(1);
            tcount_next = '0;
            phase_next  = PH_BODY;
          end else begin
            mem_we     = 1'b1;
            count_next = count + 1'b1;
            if (phase == PH_BODY) begin
              if (rx_byte == end_byte) begin
                phase_next  = PH_TRAIL;
                tcount_next = '0;
              end
            end else begin
              tcount_next = tcount_inc;
              if (tcount_inc == TCNT_W'(TRAILER_LEN)) begin
                cmd_push    = 1'b1;
                hold_next   = 1'b1;
                phase_next  = PH_IDLE;
                count_next  = '0;
                tcount_next = '0;
              end
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (rx_byte == start_byte) begin
            mem_we      = 1'b1;
            mem_waddr   = '0;
            count_next  = CNT_W'(1);
            tcount_next = '0;
            phase_next  = PH_BODY;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      count       <= '0;
      tcount      <= '0;
      hold        <= 1'b0;
      start_byte  <= START_RESET;
      end_byte    <= END_RESET;
      escape_byte <= ESCAPE_RESET;
    end else begin
      phase  <= phase_next;
      count  <= count_next;
      tcount <= tcount_next;
      hold   <= hold_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_START:  start_byte  <= cfg_data;
          REG_END:    end_byte    <= cfg_data;
          REG_ESCAPE: escape_byte <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  // Shadow copies of the two bytes that can hold the command.
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == ADDR_W'(1)) begin
      byte1 <= mem_wdata;
    end
    if (mem_we && mem_waddr == ADDR_W'(2)) begin
      byte2 <= mem_wdata;
    end
  end

endmodule

### rtl/core/sedf_back.sv
`include "stx_etx_packet_deframer_defines.svh"

module sedf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_push,
  input  sedf_pkg::cmd_t              cmd,
  output sedf_pkg::back_status_t      status,
  output logic [sedf_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [7:0]                  mem_rdata,
  output logic                        empty,
  input  logic                        pop,
  output sedf_pkg::out_item_t         head_item
);

  import sedf_pkg::*;

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  // Command queue between the front and this sequencer.
  cmd_t       q [2];
  logic       q_wp, q_rp;
  logic [1:0] q_cnt;
  cmd_t       q_head;

  // Output queue holding finished beats.
  out_item_t            oq [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] oq_wp, oq_rp;
  logic [OUT_CNT_W-1:0] oc;

  state_t           state;
  logic [CNT_W-1:0] len;
  logic [ADDR_W-1:0] rd_addr;
  logic             rd_valid, rd_last;

  logic      issue, last_issue, err_go, frm_go, q_pop;
  logic      oq_push, oq_pop;
  out_item_t oq_in;

  assign q_head = q[q_rp];
  assign status.cmd_full = (q_cnt == 2'd2);
  assign mem_raddr = rd_addr;

  // A read is issued only when its beat is sure to find room in the output queue.
  assign issue = (state == ST_READ) &&
                 ((oc + OUT_CNT_W'(rd_valid)) < OUT_CNT_W'(OUT_DEPTH));
  assign last_issue = issue && ((CNT_W'(rd_addr) + 1'b1) == len);
  assign status.frame_done = last_issue;

  assign err_go = (state == ST_IDLE) && (q_cnt != 2'd0) && q_head.is_err &&
                  !rd_valid && (oc < OUT_CNT_W'(OUT_DEPTH));
  assign frm_go = (state == ST_IDLE) && (q_cnt != 2'd0) && !q_head.is_err;
  assign q_pop  = err_go || frm_go;

  assign oq_push = rd_valid || err_go;
  assign oq_pop  = pop && (oc != '0);
  assign empty   = (oc == '0);
  assign head_item = oq[oq_rp];

  always_comb begin
    if (rd_valid) begin
      oq_in.kind = KIND_DATA;
      oq_in.data = mem_rdata;
      oq_in.last = rd_last;
    end else begin
      oq_in.kind = KIND_ERROR;
      oq_in.data = q_head.data;
      oq_in.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_valid <= 1'b0;
      q_wp     <= 1'b0;
      q_rp     <= 1'b0;
      q_cnt    <= '0;
      oq_wp    <= '0;
      oq_rp    <= '0;
      oc       <= '0;
    end else begin
      rd_valid <= issue;
      unique case (state)
        ST_IDLE: begin
          if (frm_go) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (last_issue) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cmd_push) begin
        q_wp <= ~q_wp;
      end
      if (q_pop) begin
        q_rp <= ~q_rp;
      end
      q_cnt <= q_cnt + {1'b0, cmd_push} - {1'b0, q_pop};
      if (oq_push) begin
        oq_wp <= oq_wp + 1'b1;
      end
      if (oq_pop) begin
        oq_rp <= oq_rp + 1'b1;
      end
      oc <= oc + OUT_CNT_W'(oq_push) - OUT_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_push) begin
      q[q_wp] <= cmd;
    end
    if (oq_push) begin
      oq[oq_wp] <= oq_in;
    end
    if (frm_go) begin
      len     <= q_head.len;
      rd_addr <= '0;
    end else if (issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (issue) begin
      rd_last <= last_issue;
    end
  end

  `SEDF_ASSERT_SAME(a_oq_bound, 1'b1, oc <= OUT_CNT_W'(OUT_DEPTH))
  `SEDF_ASSERT_NEXT(a_read_lands, issue, rd_valid)
  `SEDF_ASSERT_SAME(a_beat_has_room, rd_valid, oc < OUT_CNT_W'(OUT_DEPTH))
  `SEDF_ASSERT_SAME(a_no_queue_overrun, cmd_push, q_cnt != 2'd2)

endmodule

### rtl/core/stx_etx_packet_deframer.sv
// Accepts one byte per cycle while full is low; a finished frame then blocks input until
// its bytes are read out of the frame buffer, which takes longer if the output backs up.
// The first frame byte passes the command queue, the sequencer state, the buffer read
// and the output queue registers; a length error passes the command and output queues.
// Synchronous reset clears the state machines, counters and queue pointers and loads the
// register defaults; the frame buffer and queue contents are not cleared.
module stx_etx_packet_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic       last
);

  import sedf_pkg::*;

  back_status_t      status;
  cmd_t              cmd;
  logic              cmd_push;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  out_item_t         head_item;

  assign cfg_ready = 1'b1;
  assign kind      = head_item.kind;
  assign data_byte = head_item.data;
  assign last      = head_item.last;

  sedf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .status    (status),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  sedf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sedf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .status    (status),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .empty     (empty),
    .pop       (pop),
    .head_item (head_item)
  );

endmodule

### test/stx_etx_packet_deframer_checker.sv
module stx_etx_packet_deframer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] rx_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic       kind,
  input  logic [7:0] data_byte,
  input  logic       last,
  output int         n_errors,
  output int         n_pending
);

  import sedf_pkg::*;

  typedef enum logic [1:0] {PH_WAIT, PH_BODY, PH_TRAIL} rx_phase_t;

  logic [7:0] start_val;
  logic [7:0] end_val;
  logic [7:0] esc_val;
  rx_phase_t  rx_phase;
  int         held;
  int         trail_cnt;
  logic [7:0] frame_buf [MAX_FRAME];
  out_item_t  frame_out_q [$];
  int         fail_cnt = 0;
  int         wait_cnt = 0;

  assign n_errors  = fail_cnt;
  assign n_pending = wait_cnt;

  task automatic open_frame(input logic [7:0] b);
    frame_buf[0] = b;
    held         = 1;
    trail_cnt    = 0;
    rx_phase     = PH_BODY;
  endtask

  task automatic close_frame();
    held      = 0;
    trail_cnt = 0;
    rx_phase  = PH_WAIT;
  endtask

  // Works out what one received byte does to the frame and queues the results.
  task automatic deframe_byte(input logic [7:0] b);
    out_item_t item;
    if (rx_phase == PH_BODY || rx_phase == PH_TRAIL) begin
      if (held == MAX_FRAME) begin
        // The store is full, so the frame is dropped and only its command byte is reported.
        item.kind = KIND_ERROR;
        item.data = (frame_buf[1] == esc_val) ? frame_buf[2] : frame_buf[1];
        item.last = 1'b1;
        frame_out_q.push_back(item);
        close_frame();
      end else begin
        frame_buf[held] = b;
        held++;
        if (rx_phase == PH_TRAIL)
          trail_cnt++;
        if (b == start_val) begin
          open_frame(b);
        end else if (rx_phase == PH_BODY) begin
          if (b == end_val) begin
            trail_cnt = 0;
            rx_phase  = PH_TRAIL;
          end
        end else if (trail_cnt == TRAILER_LEN) begin
          for (int k = 0; k < held; k++) begin
            item.kind = KIND_DATA;
            item.data = frame_buf[k];
            item.last = (k == held - 1);
            frame_out_q.push_back(item);
          end
          close_frame();
        end
      end
    end else begin
      rx_phase = PH_WAIT;
      if (b == start_val)
        open_frame(b);
    end
  endtask

  task automatic check_beat();
    out_item_t want;
    if (frame_out_q.size() == 0) begin
      $error("unexpected result beat: kind %0d data_byte 0x%02h last %0d",
             kind, data_byte, last);
      fail_cnt++;
    end else begin
      want = frame_out_q.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        fail_cnt++;
      end
      if (data_byte !== want.data) begin
        $error("data_byte: expected 0x%02h, got 0x%02h", want.data, data_byte);
        fail_cnt++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        fail_cnt++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_val = START_RESET;
      end_val   = END_RESET;
      esc_val   = ESCAPE_RESET;
      close_frame();
      frame_out_q.delete();
    end else begin
      if (pop && !empty)
        check_beat();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START:  start_val = cfg_data;
          REG_END:    end_val   = cfg_data;
          REG_ESCAPE: esc_val   = cfg_data;
          default: ;
        endcase
      end
      if (push && !full)
        deframe_byte(rx_byte);
    end
    wait_cnt = frame_out_q.size();
  end

  final begin
    if (frame_out_q.size() != 0)
      $error("%0d result beats never arrived", frame_out_q.size());
  end

endmodule

### test/tb_stx_etx_packet_deframer.sv
module tb_stx_etx_packet_deframer;
  import sedf_pkg::*;

  // Writes to this index land outside the register list and must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       push;
  logic       full;
  logic [7:0] rx_byte;
  logic       empty;
  logic       pop;
  logic       kind;
  logic [7:0] data_byte;
  logic       last;

  int         fail_count;
  int         pending;
  int         n_sent = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  bit         hold_req = 1'b0;
  logic [7:0] cur_start = START_RESET;
  logic [7:0] cur_end = END_RESET;
  logic [7:0] cur_esc = ESCAPE_RESET;

  // Bytes before any start, a minimal frame, then restarts inside the body and the trailer.
  logic [7:0] opening [20] = '{8'h00, 8'hFF, 8'h02, 8'h03, 8'h00, 8'hFF, 8'h55, 8'hAA,
                               8'h02, 8'h41, 8'h02, 8'h7F, 8'h03, 8'h11, 8'h02, 8'h03,
                               8'h04, 8'h05, 8'h06, 8'h07};

  stx_etx_packet_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last)
  );

  stx_etx_packet_deframer_checker frame_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last),
    .n_errors  (fail_count),
    .n_pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop      = 1'b0;
        repeat (400) @(negedge clk);
      end
      pop = (rx_idle_on && $urandom_range(99) < 32) ? 1'b0 : 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    while (tx_idle_on && $urandom_range(99) < 32) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (full);
    @(negedge clk);
    n_sent++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == cur_start || b == cur_end);
    return b;
  endfunction

  function automatic logic [7:0] trailer_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == cur_start);
    return b;
  endfunction

  function automatic int frame_len();
    return ($urandom_range(9) == 0) ? $urandom_range(7, 58) : $urandom_range(0, 6);
  endfunction

  task automatic send_frame(input int body_len);
    send_byte(cur_start);
    repeat (body_len) send_byte(plain_byte());
    send_byte(cur_end);
    repeat (TRAILER_LEN) send_byte(trailer_byte());
  endtask

  // Fills the store to the brim, either in the body or three bytes into the trailer.
  task automatic send_overflow(input bit in_trailer, input bit want_esc);
    int body_len;
    body_len = in_trailer ? 59 : 63;
    send_byte(cur_start);
    if (want_esc && cur_esc != cur_start && cur_esc != cur_end)
      send_byte(cur_esc);
    else
      send_byte(plain_byte());
    repeat (body_len - 1) send_byte(plain_byte());
    if (in_trailer) begin
      send_byte(cur_end);
      repeat (3) send_byte(trailer_byte());
    end
    // The overflow check wins, so even a start byte here is dropped.
    send_byte(cur_start);
  endtask

  task automatic run_traffic(input int quota);
    int first;
    int pick;
    first = n_sent;
    while (n_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame(frame_len());
      end else if (pick < 72) begin
        send_byte(cur_start);
        repeat ($urandom_range(1, 4)) send_byte(plain_byte());
        send_frame(frame_len());
      end else if (pick < 84) begin
        send_byte(cur_start);
        repeat ($urandom_range(0, 3)) send_byte(plain_byte());
        send_byte(cur_end);
        repeat ($urandom_range(0, 3)) send_byte(trailer_byte());
        send_frame(frame_len());
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic settle();
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_ESCAPE, x);
    cur_start = s;
    cur_end   = e;
    cur_esc   = x;
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    rst       = 1'b1;
    push      = 1'b0;
    rx_byte   = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_START;
    cfg_data  = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening[i]) send_byte(opening[i]);
    send_overflow(1'b0, 1'b1);
    run_traffic(25);

    // The receiver stops for a long while so the block backs up and raises full.
    settle();
    set_regs(8'h00, 8'hFF, 8'hFF);
    hold_req = 1'b1;
    run_traffic(25);
    send_overflow(1'b1, 1'b0);

    settle();
    set_regs(8'hFF, 8'h00, 8'h00);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_traffic(35);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    settle();
    s = 8'($urandom);
    do e = 8'($urandom); while (e == s);
    set_regs(s, e, 8'($urandom));
    write_reg(REG_SPARE, 8'($urandom));
    send_overflow(1'b0, 1'($urandom));
    run_traffic(25);

    settle();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
